@@ rtl/core/bsmh_pkg.sv @@
// shared types, seeds and rotate/round helpers for the byte stream mixing hash
// no dependencies; used by bsmh_absorb, bsmh_final and the top level
package bsmh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PhaseW = 4;

  localparam logic [WordW-1:0] SeedA = 32'h0123_4567;
  localparam logic [WordW-1:0] SeedB = 32'h89AB_CDEF;
  localparam logic [WordW-1:0] SeedC = 32'hFEDC_BA98;
  localparam logic [WordW-1:0] SeedD = 32'h7654_3210;

  // position within a 16 byte block at which the cross mix fires
  localparam logic [PhaseW-1:0] PhaseLast = 4'd15;

  typedef struct packed {
    logic [WordW-1:0] d;
    logic [WordW-1:0] c;
    logic [WordW-1:0] b;
    logic [WordW-1:0] a;
  } words_t;

  localparam words_t SeedWords = '{d: SeedD, c: SeedC, b: SeedB, a: SeedA};

  // rotate left by a constant amount in 1..31
  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned k);
    rotl = (x << k) | (x >> (WordW - k));
  endfunction

  // one finalization round
  function automatic words_t fin_round(input words_t w);
    words_t r;
    r.a = rotl(w.a, 13) + w.d;
    r.b = rotl(w.b, 17) ^ r.a;
    r.c = rotl(w.c, 7) + r.b;
    r.d = rotl(w.d, 11) ^ r.c;
    fin_round = r;
  endfunction

endpackage

@@ rtl/core/bsmh_absorb.sv @@
// per-byte absorb step, cross mix and length fold-in of the mixing words
// depends on bsmh_pkg
module bsmh_absorb (
  input  bsmh_pkg::words_t                 mix_i,
  input  logic [bsmh_pkg::WordW-1:0]       count_i,
  input  logic [bsmh_pkg::PhaseW-1:0]      phase_i,
  input  logic [7:0]                       byte_i,
  input  logic                             byte_valid_i,
  output bsmh_pkg::words_t                 mix_o,
  output logic [bsmh_pkg::WordW-1:0]       count_o,
  output logic [bsmh_pkg::PhaseW-1:0]      phase_o,
  output bsmh_pkg::words_t                 prep_o
);

  logic [bsmh_pkg::WordW-1:0] byte_ext;
  bsmh_pkg::words_t           upd;
  bsmh_pkg::words_t           crossed;

  assign byte_ext = {{(bsmh_pkg::WordW-8){1'b0}}, byte_i};

  always_comb begin
    upd.a = bsmh_pkg::rotl(mix_i.a, 5) ^ byte_ext;
    upd.b = bsmh_pkg::rotl(mix_i.b, 7) + byte_ext;
    // times 33 as shift plus add
    upd.c = (mix_i.c << 5) + mix_i.c + ~byte_ext;
    upd.d = bsmh_pkg::rotl(mix_i.d, 29) ^ byte_ext;

    crossed.a = upd.b ^ upd.c;
    crossed.b = upd.c + upd.d;
    crossed.c = upd.d ^ upd.a;
    crossed.d = upd.a + crossed.a;

    if (!byte_valid_i) begin
      mix_o = mix_i;
    end else if (phase_i == bsmh_pkg::PhaseLast) begin
      mix_o = crossed;
    end else begin
      mix_o = upd;
    end
  end

  assign count_o = count_i + {{(bsmh_pkg::WordW-1){1'b0}}, byte_valid_i};
  assign phase_o = phase_i + {{(bsmh_pkg::PhaseW-1){1'b0}}, byte_valid_i};

  // fold the length into the words ahead of the rounds
  always_comb begin
    prep_o.a = mix_o.a ^ count_o;
    prep_o.b = mix_o.b + count_o;
    prep_o.c = mix_o.c ^ (prep_o.a ^ prep_o.b);
    prep_o.d = mix_o.d + (prep_o.b ^ prep_o.c);
  end

endmodule

@@ rtl/core/bsmh_final.sv @@
// three finalization rounds that turn the folded words into the digest
// depends on bsmh_pkg
module bsmh_final (
  input  bsmh_pkg::words_t prep_i,
  output bsmh_pkg::words_t digest_o
);

  bsmh_pkg::words_t r1;
  bsmh_pkg::words_t r2;

  assign r1       = bsmh_pkg::fin_round(prep_i);
  assign r2       = bsmh_pkg::fin_round(r1);
  assign digest_o = bsmh_pkg::fin_round(r2);

endmodule

@@ rtl/core/byte_stream_mixing_hash_128_unit.sv @@
// top level of the byte stream mixing hash with 128-bit digest
// depends on bsmh_pkg, bsmh_absorb and bsmh_final
//
// Takes one word per cycle on the slave stream: a message byte in tdata, tuser
// set when that byte is present, tlast closing the message. Each word is
// registered, then absorbed into four 32-bit mixing words, a byte count and a
// position counter; after every 16th byte the words are cross mixed. A word
// with tlast also folds in the length and lands in a finalization register;
// from there three rotate rounds run into the output register once it is free,
// and the state returns to its seeds. Sustained rate is one word per clock
// while no closing word waits on a full finalization register; a digest goes
// through the finalization and then the output register. The per-byte absorb
// feeds the mixing registers back on themselves. Back pressure ripples stage
// by stage, so input stays open while a finished digest waits for the sink.
module byte_stream_mixing_hash_128_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] byte_valid
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] digest_word_a, [63:32] digest_word_b, [95:64] digest_word_c,
  // [127:96] digest_word_d, [159:128] message_length
  output logic [159:0] m_axis_tdata
);

  localparam int unsigned W = bsmh_pkg::WordW;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_bval_q;
  logic       in_last_q;

  // hash state
  bsmh_pkg::words_t             mix_q;
  logic [W-1:0]                 count_q;
  logic [bsmh_pkg::PhaseW-1:0]  phase_q;

  // finalization register
  logic             fin_valid_q;
  bsmh_pkg::words_t fin_words_q;
  logic [W-1:0]     fin_len_q;

  // output register
  logic             out_valid_q;
  bsmh_pkg::words_t out_digest_q;
  logic [W-1:0]     out_len_q;

  bsmh_pkg::words_t            mix_d;
  logic [W-1:0]                count_d;
  logic [bsmh_pkg::PhaseW-1:0] phase_d;
  bsmh_pkg::words_t            prep;
  bsmh_pkg::words_t            digest;

  logic s_fire;
  logic out_ready;
  logic fin_ready;
  logic step_go;
  logic fin_go;

  // stage handshakes, each stage frees when its word moves on
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign fin_ready     = !fin_valid_q || out_ready;
  // only a closing word needs a free finalization slot
  assign step_go       = in_valid_q && (!in_last_q || fin_ready);
  assign fin_go        = fin_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || step_go;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  bsmh_absorb u_absorb (
    .mix_i        (mix_q),
    .count_i      (count_q),
    .phase_i      (phase_q),
    .byte_i       (in_byte_q),
    .byte_valid_i (in_bval_q),
    .mix_o        (mix_d),
    .count_o      (count_d),
    .phase_o      (phase_d),
    .prep_o       (prep)
  );

  bsmh_final u_final (
    .prep_i   (fin_words_q),
    .digest_o (digest)
  );

  // control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      mix_q       <= bsmh_pkg::SeedWords;
      count_q     <= '0;
      phase_q     <= '0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_go) begin
        in_valid_q <= 1'b0;
      end

      if (step_go) begin
        if (in_last_q) begin
          // message closed, back to the seeds
          mix_q   <= bsmh_pkg::SeedWords;
          count_q <= '0;
          phase_q <= '0;
        end else begin
          mix_q   <= mix_d;
          count_q <= count_d;
          phase_q <= phase_d;
        end
      end

      if (step_go && in_last_q) begin
        fin_valid_q <= 1'b1;
      end else if (fin_go) begin
        fin_valid_q <= 1'b0;
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_bval_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
    if (step_go && in_last_q) begin
      fin_words_q <= prep;
      fin_len_q   <= count_d;
    end
    if (fin_go) begin
      out_digest_q <= digest;
      out_len_q    <= fin_len_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_digest_q.d, out_digest_q.c,
                          out_digest_q.b, out_digest_q.a};

endmodule

@@ rtl/core/bsmh_checker.sv @@
// port level checks for the byte stream mixing hash unit, with its bind
// depends on byte_stream_mixing_hash_128_unit
module bsmh_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata
);

  // a pending digest stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("digest dropped while stalled");

  // a stalled digest holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("digest changed while stalled");

  // with the output side free, input must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while output side free");

  // nothing offered once reset has been seen
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("digest offered during reset");

endmodule

bind byte_stream_mixing_hash_128_unit bsmh_checker u_bsmh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/byte_stream_mixing_hash_128_unit_tb.sv @@
// self-checking bench for byte_stream_mixing_hash_128_unit: random and directed messages,
// random gaps on both streams, digests checked against an in-bench hash predictor
// depends on bsmh_pkg (seeds) and the rtl of the unit

class digest_scoreboard;
  // predictor copy of the hash state
  bit [31:0]  hash_a;
  bit [31:0]  hash_b;
  bit [31:0]  hash_c;
  bit [31:0]  hash_d;
  bit [31:0]  bytes_seen;
  bit [3:0]   block_pos;
  // digests still owed by the unit, oldest first
  bit [159:0] owed_digests[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
    reseed();
  endfunction

  function void reseed();
    hash_a     = bsmh_pkg::SeedA;
    hash_b     = bsmh_pkg::SeedB;
    hash_c     = bsmh_pkg::SeedC;
    hash_d     = bsmh_pkg::SeedD;
    bytes_seen = '0;
    block_pos  = '0;
  endfunction

  function bit [31:0] rot_left(bit [31:0] x, int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  function void mix_in_byte(bit [7:0] data_b);
    bit [31:0] wide;
    bit [31:0] old_a;
    wide   = {24'd0, data_b};
    hash_a = rot_left(hash_a, 5) ^ wide;
    hash_b = rot_left(hash_b, 7) + wide;
    hash_c = hash_c * 32'd33 + ~wide;
    hash_d = rot_left(hash_d, 29) ^ wide;
    // cross mix closes each 16 byte block
    if (block_pos == 4'd15) begin
      old_a  = hash_a;
      hash_a = hash_b ^ hash_c;
      hash_b = hash_c + hash_d;
      hash_c = hash_d ^ old_a;
      hash_d = old_a + hash_a;
    end
    block_pos  = block_pos + 4'd1;
    bytes_seen = bytes_seen + 32'd1;
  endfunction

  // called for every word the unit accepts
  function void note_word(bit [7:0] data_b, bit present, bit closing);
    bit [31:0]  fa, fb, fc, fd, len;
    bit [159:0] entry;
    if (present) mix_in_byte(data_b);
    if (!closing) return;
    len = bytes_seen;
    fa  = hash_a ^ len;
    fb  = hash_b + len;
    fc  = hash_c ^ (fa ^ fb);
    fd  = hash_d + (fb ^ fc);
    for (int r = 0; r < 3; r++) begin
      fa = rot_left(fa, 13) + fd;
      fb = rot_left(fb, 17) ^ fa;
      fc = rot_left(fc, 7) + fb;
      fd = rot_left(fd, 11) ^ fc;
    end
    entry        = {len, fd, fc, fb, fa};
    owed_digests = {owed_digests, entry};
    reseed();
  endfunction

  // called for every digest the sink accepts
  function void check_digest(bit [159:0] got);
    bit [159:0] want;
    string      field_names [5];
    field_names = '{"digest_word_a", "digest_word_b", "digest_word_c",
                    "digest_word_d", "message_length"};
    if (owed_digests.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected digest word %h", got);
      return;
    end
    want = owed_digests.pop_front();
    for (int f = 0; f < 5; f++) begin
      if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch: expected %h, got %h", field_names[f],
                   want[f*32 +: 32], got[f*32 +: 32]);
      end
    end
  endfunction
endclass

module byte_stream_mixing_hash_128_unit_tb;

  // clock, reset and stream signals; the ones the bench drives are known from time zero
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'd0;   // [7:0] byte_value
  logic         s_axis_tuser  = 1'b0;   // [0] byte_valid
  logic         s_axis_tlast  = 1'b0;   // is_last
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] digest_word_a, [63:32] digest_word_b, [95:64] digest_word_c,
  // [127:96] digest_word_d, [159:128] message_length
  logic [159:0] m_axis_tdata;

  // set during the stretch where neither side idles
  bit no_idle = 1'b0;
  // every word the unit has accepted
  int unsigned counted_words = 0;

  digest_scoreboard hash_sb = new();

  byte_stream_mixing_hash_128_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sink side: drop ready about 31 times in 100 outside the no-idle stretch
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 31);
  end

  // digest monitor; sampled mid-cycle so the handshake seen is the one taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      hash_sb.check_digest(m_axis_tdata);
  end

  // present one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input logic [7:0] data_b, input logic present,
                           input logic closing);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= closing;
    // ready is stable by the falling edge, so the word goes in at the next rising edge
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    hash_sb.note_word(data_b, present, closing);
    counted_words++;
  endtask

  // random byte, leaning on the extremes now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one message of len bytes; closes either on its last byte or with a byte-less word,
  // with a sprinkle of ignored words in between
  task automatic send_message(input int unsigned len);
    bit close_on_byte;
    close_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5)
        send_word(pick_byte(), 1'b0, 1'b0);
      send_word(pick_byte(), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte)
      send_word(pick_byte(), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned msg_len;
    int unsigned drain_cycles;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part
    // empty message: finalize with no byte at all
    send_word(8'h5A, 1'b0, 1'b1);
    // one-byte messages at both byte extremes, closed on the byte
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    // ignored word, then a byte closed by a separate finalize word
    send_word(8'hC3, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // a full 16 byte block: cross mix and finalize on the same word
    for (int i = 0; i < 16; i++)
      send_word((i % 2) ? 8'hFF : 8'h00, 1'b1, i == 15);

    // random part: mostly short messages, a few long ones
    while (counted_words < 1550) begin
      no_idle = (counted_words >= 500) && (counted_words < 750);
      case ($urandom_range(0, 9))
        0:       msg_len = $urandom_range(49, 140);
        1, 2:    msg_len = $urandom_range(21, 48);
        default: msg_len = $urandom_range(0, 20);
      endcase
      send_message(msg_len);
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain: wait for the owed digests, then let the clock run on past the pipeline depth
    drain_cycles = 0;
    while (hash_sb.owed_digests.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (20) @(posedge clk_i);

    if (hash_sb.mismatches == 0 && hash_sb.owed_digests.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bsmh_pkg.sv
rtl/core/bsmh_absorb.sv
rtl/core/bsmh_final.sv
rtl/core/byte_stream_mixing_hash_128_unit.sv
rtl/core/bsmh_checker.sv
bench/byte_stream_mixing_hash_128_unit_tb.sv
